/* hdl/capdu_pkg.sv */
// shared types and codes of the command apdu parser
`default_nettype none
package capdu_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned LE_W = 17;

  localparam logic [TOTAL_W-1:0] MIN_APDU_LEN = 17'd4;
  localparam logic [TOTAL_W-1:0] LC_FIRST_POS = 17'd4;
  localparam logic [TOTAL_W-1:0] LC_SECOND_POS = 17'd5;
  localparam logic [TOTAL_W-1:0] EXT_LC_MIN_REM = 17'd2;
  localparam logic [LE_W-1:0] LE_EXT_ZERO = 17'h10000;

  typedef enum logic [2:0] {
    PH_CLA  = 3'd0,
    PH_INS  = 3'd1,
    PH_P1   = 3'd2,
    PH_P2   = 3'd3,
    PH_LC   = 3'd4,
    PH_BODY = 3'd5,
    PH_LE   = 3'd6,
    PH_IGN  = 3'd7
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_byte;
    logic [TOTAL_W-1:0] total_length;
  } beat_t;

  typedef struct packed {
    logic [2:0]         byte_role;
    logic [DATA_W-1:0]  data_out;
    logic [COUNT_W-1:0] body_index;
    logic               apdu_done;
    logic               parse_ok;
    logic [DATA_W-1:0]  ins_value;
    logic [DATA_W-1:0]  p1_value;
    logic [DATA_W-1:0]  p2_value;
    logic [COUNT_W-1:0] body_length;
    logic [LE_W-1:0]    max_response_length;
  } result_t;

  typedef struct packed {
    logic valid;
    logic take;
  } stage_hs_t;

endpackage
`default_nettype wire

/* hdl/capdu_in_stage.sv */
// input register stage of the command apdu parser
`default_nettype none
module capdu_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire capdu_pkg::beat_t   in_beat,
  input  wire logic               take,
  output capdu_pkg::stage_hs_t    hs,
  output capdu_pkg::beat_t        beat
);

  logic              valid_r;
  capdu_pkg::beat_t  beat_r;

  assign in_stall = valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat_r <= in_beat;
    end
  end

  assign hs.valid = valid_r;
  assign hs.take = take;
  assign beat = beat_r;

endmodule
`default_nettype wire

/* hdl/capdu_parser.sv */
// parse state and per-byte decode of the command apdu parser
`default_nettype none
module capdu_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire capdu_pkg::stage_hs_t hs,
  input  wire capdu_pkg::beat_t     beat,
  output capdu_pkg::result_t        res
);

  logic [capdu_pkg::TOTAL_W-1:0] pos_r, pos_nxt;
  capdu_pkg::phase_t             phase_r, phase_nxt;
  logic [capdu_pkg::COUNT_W-1:0] lc_r, lc_nxt;
  logic [capdu_pkg::COUNT_W-1:0] bc_r, bc_nxt;
  logic [capdu_pkg::LE_W-1:0]    le_r, le_nxt;
  logic [capdu_pkg::DATA_W-1:0]  ins_r, ins_nxt;
  logic [capdu_pkg::DATA_W-1:0]  p1_r, p1_nxt;
  logic [capdu_pkg::DATA_W-1:0]  p2_r, p2_nxt;
  logic                          failed_r, failed_nxt;

  logic [capdu_pkg::DATA_W-1:0]  b;
  logic [capdu_pkg::TOTAL_W-1:0] tot;
  logic [capdu_pkg::TOTAL_W-1:0] rem;
  logic                          rem_zero;
  logic [capdu_pkg::COUNT_W-1:0] lc_new;
  logic                          lc_final;
  logic [capdu_pkg::COUNT_W-1:0] bc_inc;
  logic [capdu_pkg::COUNT_W-1:0] le_pair;
  logic                          done;
  logic                          advance;

  assign b = beat.data_byte;
  assign tot = (beat.total_length == '0) ? 17'd1 : beat.total_length;
  assign rem = (tot > pos_r) ? (tot - pos_r - 17'd1) : '0;
  assign rem_zero = (rem == '0);
  assign bc_inc = bc_r + 16'd1;
  assign le_pair = {le_r[capdu_pkg::DATA_W-1:0], b};
  assign done = rem_zero;
  assign advance = hs.valid && hs.take;

  // lc byte decode, short or extended
  always_comb begin
    lc_new = lc_r | {8'd0, b};
    lc_final = 1'b1;
    if (pos_r == capdu_pkg::LC_FIRST_POS) begin
      lc_new = {8'd0, b};
      lc_final = !((b == '0) && (rem > capdu_pkg::EXT_LC_MIN_REM));
    end else if (pos_r == capdu_pkg::LC_SECOND_POS) begin
      lc_new = {b, 8'd0};
      lc_final = 1'b0;
    end
  end

  // next state
  always_comb begin
    pos_nxt = pos_r + 17'd1;
    phase_nxt = phase_r;
    lc_nxt = lc_r;
    bc_nxt = bc_r;
    le_nxt = le_r;
    ins_nxt = ins_r;
    p1_nxt = p1_r;
    p2_nxt = p2_r;
    failed_nxt = failed_r;
    case (phase_r)
      capdu_pkg::PH_CLA: begin
        if ((tot < capdu_pkg::MIN_APDU_LEN) || (b != '0)) begin
          failed_nxt = 1'b1;
          phase_nxt = capdu_pkg::PH_IGN;
        end else begin
          phase_nxt = capdu_pkg::PH_INS;
        end
      end
      capdu_pkg::PH_INS: begin
        ins_nxt = b;
        phase_nxt = capdu_pkg::PH_P1;
      end
      capdu_pkg::PH_P1: begin
        p1_nxt = b;
        phase_nxt = capdu_pkg::PH_P2;
      end
      capdu_pkg::PH_P2: begin
        p2_nxt = b;
        lc_nxt = '0;
        phase_nxt = rem_zero ? capdu_pkg::PH_IGN : capdu_pkg::PH_LC;
      end
      capdu_pkg::PH_LC: begin
        lc_nxt = lc_new;
        if (lc_final) begin
          bc_nxt = '0;
          if (lc_new == '0) begin
            phase_nxt = rem_zero ? capdu_pkg::PH_IGN : capdu_pkg::PH_LE;
          end else if (rem < {1'b0, lc_new}) begin
            failed_nxt = 1'b1;
            phase_nxt = capdu_pkg::PH_IGN;
          end else begin
            phase_nxt = capdu_pkg::PH_BODY;
          end
        end
      end
      capdu_pkg::PH_BODY: begin
        bc_nxt = bc_inc;
        if (bc_inc == lc_r) begin
          bc_nxt = '0;
          phase_nxt = rem_zero ? capdu_pkg::PH_IGN : capdu_pkg::PH_LE;
        end
      end
      capdu_pkg::PH_LE: begin
        if (bc_r == '0) begin
          le_nxt = {9'd0, b};
          bc_nxt = 16'd1;
          if (rem_zero) begin
            phase_nxt = capdu_pkg::PH_IGN;
          end
        end else begin
          le_nxt = (le_pair == '0) ? capdu_pkg::LE_EXT_ZERO : {1'b0, le_pair};
          phase_nxt = capdu_pkg::PH_IGN;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // result fields
  always_comb begin
    res.byte_role = phase_r;
    res.data_out = b;
    res.body_index = (phase_r == capdu_pkg::PH_BODY) ? bc_r : '0;
    res.apdu_done = done;
    res.parse_ok = done && !failed_nxt &&
                   !((phase_nxt == capdu_pkg::PH_INS) || (phase_nxt == capdu_pkg::PH_P1) ||
                     (phase_nxt == capdu_pkg::PH_P2) || (phase_nxt == capdu_pkg::PH_LC) ||
                     (phase_nxt == capdu_pkg::PH_BODY));
    res.ins_value = ins_nxt;
    res.p1_value = p1_nxt;
    res.p2_value = p2_nxt;
    res.body_length = lc_nxt;
    res.max_response_length = le_nxt;
  end

  // last byte of an apdu clears the state for the next one
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && done)) begin
      pos_r <= '0;
      phase_r <= capdu_pkg::PH_CLA;
      lc_r <= '0;
      bc_r <= '0;
      le_r <= '0;
      ins_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
      failed_r <= 1'b0;
    end else if (advance) begin
      pos_r <= pos_nxt;
      phase_r <= phase_nxt;
      lc_r <= lc_nxt;
      bc_r <= bc_nxt;
      le_r <= le_nxt;
      ins_r <= ins_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/capdu_out_stage.sv */
// result register stage of the command apdu parser
`default_nettype none
module capdu_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 s1_valid,
  input  wire capdu_pkg::result_t   res_in,
  output logic                      take,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output capdu_pkg::result_t        res_out
);

  logic                 valid_r;
  capdu_pkg::result_t   res_r;

  assign take = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && s1_valid) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out = res_r;

endmodule
`default_nettype wire

/* hdl/command_apdu_parser.sv */
// top level of the command apdu parser
//
//  channel  direction  handshake             beat
//  in_      input      in_valid / in_stall   data_byte, total_length
//  out_     output     out_valid / out_stall role, byte, index, done, ok, header, lc, le
//
// one result beat per input beat, one beat per cycle sustained while out_stall is low
// path: input register, then decode into the result register
// rate set by the state update of the parse registers
// synchronous reset clears the parse state and both stage valids, no clearing pass
// in_stall rises only when the input register is full and the result register is held
`default_nettype none
module command_apdu_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic [16:0]  in_total_length,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_byte_role,
  output logic [7:0]        out_data_out,
  output logic [15:0]       out_body_index,
  output logic              out_apdu_done,
  output logic              out_parse_ok,
  output logic [7:0]        out_ins_value,
  output logic [7:0]        out_p1_value,
  output logic [7:0]        out_p2_value,
  output logic [15:0]       out_body_length,
  output logic [16:0]       out_max_response_length
);

  capdu_pkg::beat_t     in_beat;
  capdu_pkg::beat_t     s1_beat;
  capdu_pkg::stage_hs_t s1_hs;
  capdu_pkg::result_t   res_c;
  capdu_pkg::result_t   res_q;
  logic                 take;

  assign in_beat.data_byte = in_data_byte;
  assign in_beat.total_length = in_total_length;

  capdu_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .take     (take),
    .hs       (s1_hs),
    .beat     (s1_beat)
  );

  capdu_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .hs    (s1_hs),
    .beat  (s1_beat),
    .res   (res_c)
  );

  capdu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_hs.valid),
    .res_in    (res_c),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign out_byte_role = res_q.byte_role;
  assign out_data_out = res_q.data_out;
  assign out_body_index = res_q.body_index;
  assign out_apdu_done = res_q.apdu_done;
  assign out_parse_ok = res_q.parse_ok;
  assign out_ins_value = res_q.ins_value;
  assign out_p1_value = res_q.p1_value;
  assign out_p2_value = res_q.p2_value;
  assign out_body_length = res_q.body_length;
  assign out_max_response_length = res_q.max_response_length;

endmodule
`default_nettype wire
